// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL of this project.
// Clock clk_i and active-low reset rst_ni are taken from the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked property, masked while in reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
// clocked property, checked during reset as well
`define ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_RST(lbl, prop)
`endif

`endif

// ----- design/sbiq_pkg.sv -----
// Package for the stereo biquad filter: widths, coefficient register map,
// reset values and the delay settle function. No dependencies.
package sbiq_pkg;

  localparam int unsigned CHANNELS_DEF    = 2;
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  localparam int unsigned COEF_W     = 32;
  localparam int unsigned COEF_FRAC  = 28;
  localparam int unsigned COEF_COUNT = 5;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam int unsigned DELAY_W = 48;
  localparam int unsigned Y_W     = 49;
  localparam int unsigned ACC_W   = 54;
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned PROD_W  = MUL_A_W + COEF_W;
  localparam int unsigned SPLIT   = 24;
  localparam int unsigned T_W     = 34;

  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [DELAY_W-1:0] delay_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  localparam coef_t COEF_RESET [COEF_COUNT] = '{32'sh1000_0000, 32'sh0, 32'sh0, 32'sh0, 32'sh0};

  localparam acc_t ACC_DMAX = {{(ACC_W-DELAY_W+1){1'b0}}, {(DELAY_W-1){1'b1}}};
  localparam acc_t ACC_DMIN = {{(ACC_W-DELAY_W+1){1'b1}}, {(DELAY_W-1){1'b0}}};

  // saturate to 48 bits, flush -1/0/+1 LSB to zero
  function automatic delay_t settle_delay(input acc_t v);
    delay_t r;
    if (v > ACC_DMAX) begin
      r = {1'b0, {(DELAY_W-1){1'b1}}};
    end else if (v < ACC_DMIN) begin
      r = {1'b1, {(DELAY_W-1){1'b0}}};
    end else begin
      r = v[DELAY_W-1:0];
    end
    if ((r == delay_t'(1)) || (r == '1)) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

// ----- design/stereo_biquad_iir_filter_unit.sv -----
// Biquad IIR filter, transposed direct form II, one section shared by all channels.
// Depends on sbiq_pkg and assert_macros.svh.
// Each sample beat carries its channel in tuser; the filter uses that channel's two
// Q8.40 delay registers and returns one saturated sample for the same channel.
// Coefficients b0, b1, b2, a1, a2 are Q4.28 registers written through the cfg port
// (indices 0..4, others ignored), a0 is 1. All seven products go through one 33x32
// multiplier, one product per cycle; after the accept a sample steps through ST_Y, ST_N1,
// ST_N2, ST_LO1, ST_HI1, ST_LO2, ST_HI2 and ST_DONE to the result beat. The input is
// ready only when no sample is in flight; the result sits in an output register and
// the block only waits if that register is still occupied when the next result is due.
// Channels at or above CHANNELS are filtered with zero delays and leave no state.
`include "assert_macros.svh"

module stereo_biquad_iir_filter_unit #(
  parameter int unsigned CHANNELS    = sbiq_pkg::CHANNELS_DEF,
  parameter int unsigned SAMPLE_BITS = sbiq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sbiq_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sbiq_pkg::COEF_W-1:0]          cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // sample_in
  input  logic                                 s_axis_tuser,  // channel
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,  // sample_out
  output logic                                 m_axis_tuser   // out_channel
);
  import sbiq_pkg::*;

  localparam int unsigned TDATA_W   = ((SAMPLE_BITS+7)/8)*8;
  localparam int unsigned IN_SHIFT  = SAMPLE_BITS - 13;
  localparam int unsigned OUT_SHIFT = 41 - SAMPLE_BITS;
  localparam int unsigned CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned YE_W      = Y_W + 1;
  localparam int unsigned WIDE_SH   = COEF_FRAC - SPLIT;

  localparam logic signed [PROD_W-1:0] IN_HALF =
    {{(PROD_W-1){1'b0}}, 1'b1} << (IN_SHIFT-1);
  localparam logic signed [PROD_W-1:0] WIDE_HALF =
    {{(PROD_W-1){1'b0}}, 1'b1} << (WIDE_SH-1);
  localparam logic signed [YE_W-1:0] OUT_HALF =
    {{(YE_W-1){1'b0}}, 1'b1} << (OUT_SHIFT-1);
  localparam logic signed [YE_W-1:0] SMAX =
    {{(YE_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [YE_W-1:0] SMIN =
    {{(YE_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_Y, ST_N1, ST_N2, ST_LO1, ST_HI1, ST_LO2, ST_HI2, ST_DONE
  } state_e;

  state_e state_q;
  logic   m_valid_q;

  coef_t  coef_q [COEF_COUNT];
  delay_t d1_q [CHANNELS];
  delay_t d2_q [CHANNELS];

  logic signed [SAMPLE_BITS-1:0] x_q;
  logic                          ch_q;
  logic                          has_q;
  logic [CH_IDX_W-1:0]           idx_q;
  delay_t                        d1_cur_q;
  delay_t                        d2_cur_q;
  logic signed [Y_W-1:0]         y_q;
  acc_t                          n1_q;
  acc_t                          n2_q;
  logic signed [T_W-1:0]         t_q;
  logic signed [PROD_W-1:0]      prod_q;
  logic [SAMPLE_BITS-1:0]        out_sample_q;
  logic                          out_ch_q;

  logic                          in_beat;
  logic                          out_free;
  logic                          finish;
  logic                          in_has;
  logic [CH_IDX_W-1:0]           in_idx;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic signed [MUL_A_W-1:0]     mul_a;
  coef_t                         mul_b;
  logic signed [MUL_A_W-1:0]     y_lo;
  logic signed [MUL_A_W-1:0]     y_hi;
  logic signed [PROD_W-1:0]      prod_rnd;
  logic signed [PROD_W-1:0]      wide_sum;
  logic signed [PROD_W-1:0]      wide_shift;
  acc_t                          term_in;
  acc_t                          term_wide;
  logic signed [YE_W-1:0]        out_rnd;
  logic [SAMPLE_BITS-1:0]        out_sample_d;

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign finish    = (state_q == ST_DONE) && out_free;
  assign in_has    = (int'(s_axis_tuser) < CHANNELS);
  assign in_idx    = CH_IDX_W'(s_axis_tuser);
  assign in_sample = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_sample_q);
  assign m_axis_tuser  = out_ch_q;

  // multiplier operand select
  assign y_lo = MUL_A_W'({1'b0, y_q[SPLIT-1:0]});
  assign y_hi = MUL_A_W'($signed(y_q[Y_W-1:SPLIT]));

  always_comb begin
    case (state_q)
      ST_IDLE: begin
        mul_a = MUL_A_W'(in_sample);
        mul_b = coef_q[REG_B0];
      end
      ST_Y: begin
        mul_a = MUL_A_W'(x_q);
        mul_b = coef_q[REG_B1];
      end
      ST_N1: begin
        mul_a = MUL_A_W'(x_q);
        mul_b = coef_q[REG_B2];
      end
      ST_N2: begin
        mul_a = y_lo;
        mul_b = coef_q[REG_A1];
      end
      ST_LO1: begin
        mul_a = y_hi;
        mul_b = coef_q[REG_A1];
      end
      ST_HI1: begin
        mul_a = y_lo;
        mul_b = coef_q[REG_A2];
      end
      ST_LO2: begin
        mul_a = y_hi;
        mul_b = coef_q[REG_A2];
      end
      default: begin
        mul_a = y_hi;
        mul_b = coef_q[REG_A2];
      end
    endcase
  end

  // product scaling
  assign prod_rnd   = (prod_q + IN_HALF) >>> IN_SHIFT;
  assign term_in    = prod_rnd[ACC_W-1:0];
  assign wide_sum   = prod_q + PROD_W'(t_q) + WIDE_HALF;
  assign wide_shift = wide_sum >>> WIDE_SH;
  assign term_wide  = wide_shift[ACC_W-1:0];

  // output rounding and saturation
  assign out_rnd = (YE_W'(y_q) + OUT_HALF) >>> OUT_SHIFT;
  always_comb begin
    if (out_rnd > SMAX) begin
      out_sample_d = SMAX[SAMPLE_BITS-1:0];
    end else if (out_rnd < SMIN) begin
      out_sample_d = SMIN[SAMPLE_BITS-1:0];
    end else begin
      out_sample_d = out_rnd[SAMPLE_BITS-1:0];
    end
  end

  // sequencer and output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      m_valid_q    <= 1'b0;
      out_sample_q <= '0;
      out_ch_q     <= 1'b0;
    end else begin
      if (finish) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            state_q <= ST_Y;
          end
        end
        ST_Y:    state_q <= ST_N1;
        ST_N1:   state_q <= ST_N2;
        ST_N2:   state_q <= ST_LO1;
        ST_LO1:  state_q <= ST_HI1;
        ST_HI1:  state_q <= ST_LO2;
        ST_LO2:  state_q <= ST_HI2;
        ST_HI2:  state_q <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state_q      <= ST_IDLE;
            out_sample_q <= out_sample_d;
            out_ch_q     <= ch_q;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COEF_COUNT; i++) begin
        coef_q[i] <= COEF_RESET[i];
      end
    end else if (cfg_we_i && (int'(cfg_idx_i) < COEF_COUNT)) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // per-channel delay state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
    end else if (finish && has_q) begin
      d1_q[idx_q] <= settle_delay(n1_q);
      d2_q[idx_q] <= settle_delay(n2_q);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          x_q      <= in_sample;
          ch_q     <= s_axis_tuser;
          has_q    <= in_has;
          idx_q    <= in_idx;
          d1_cur_q <= in_has ? d1_q[in_idx] : '0;
          d2_cur_q <= in_has ? d2_q[in_idx] : '0;
        end
      end
      ST_Y:   y_q  <= Y_W'(term_in + ACC_W'(d1_cur_q));
      ST_N1:  n1_q <= term_in + ACC_W'(d2_cur_q);
      ST_N2:  n2_q <= term_in;
      ST_LO1: t_q  <= prod_q[SPLIT+T_W-1:SPLIT];
      ST_HI1: n1_q <= n1_q - term_wide;
      ST_LO2: t_q  <= prod_q[SPLIT+T_W-1:SPLIT];
      ST_HI2: n2_q <= n2_q - term_wide;
      default: ;
    endcase
  end

  `ASSERT_CLK(a_accept_starts, in_beat |=> (state_q == ST_Y))
  `ASSERT_CLK(a_out_from_done, $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
  `ASSERT_CLK(a_done_holds, (state_q == ST_DONE && m_valid_q && !m_axis_tready) |=> (state_q == ST_DONE))
  `ASSERT_RST(a_reset_idle, !rst_ni |=> (state_q == ST_IDLE && !m_valid_q))

endmodule

// ----- bench/stereo_biquad_iir_filter_unit_tb.sv -----
// Self-checking bench for stereo_biquad_iir_filter_unit: directed and random sample beats
// checked against a fixed-point model of the transposed direct form II biquad kept here.
// Depends on sbiq_pkg and the filter RTL.
module stereo_biquad_iir_filter_unit_tb;

  import sbiq_pkg::*;

  localparam int SW            = SAMPLE_BITS_DEF;
  localparam int DW            = ((SW + 7) / 8) * 8;
  localparam int IN_SH         = SW - 13;
  localparam int OUT_SH        = 41 - SW;
  localparam int IDLE_PCT      = 7;
  localparam int LATENCY       = 9;
  localparam int SETTLE_CYCLES = 12;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 96;
  localparam int CALM_PHASE    = 5;
  localparam int MAX_PRINTS    = 100;
  localparam int B_SPAN        = 1 << 29;    // +-2.0 in Q4.28
  localparam int A_SPAN        = 120000000;  // about +-0.45, keeps the poles inside

  typedef logic signed [127:0] wide_t;

  localparam wide_t ONE     = 1;
  localparam wide_t DLY_MAX = (ONE << (DELAY_W - 1)) - 1;
  localparam wide_t DLY_MIN = -(ONE << (DELAY_W - 1));
  localparam wide_t OUT_MAX = (ONE << (SW - 1)) - 1;
  localparam wide_t OUT_MIN = -(ONE << (SW - 1));

  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW - 1){1'b0}}};

  localparam coef_t COEF_MAX = coef_t'(32'h7FFF_FFFF);
  localparam coef_t COEF_MIN = coef_t'(32'h8000_0000);
  // x * TIE_COEF lands exactly on half an LSB of the delay format
  localparam coef_t TIE_COEF = coef_t'(1 << (IN_SH - 1));

  localparam logic [CFG_IDX_W-1:0] COEF_IDX [COEF_COUNT] =
    '{REG_B0, REG_B1, REG_B2, REG_A1, REG_A2};
  localparam logic [CFG_IDX_W-1:0] FIRST_UNMAPPED = CFG_IDX_W'(COEF_COUNT);

  typedef enum logic [1:0] {ITEM_SAMPLE, ITEM_WRITE, ITEM_DRAIN} item_kind_e;
  typedef enum logic [2:0] {MODE_STABLE, MODE_WILD, MODE_MAX, MODE_MIN, MODE_GAIN} coef_mode_e;

  typedef struct {
    item_kind_e           kind;
    logic                 chan;
    logic [SW-1:0]        sample;
    logic [CFG_IDX_W-1:0] idx;
    logic [COEF_W-1:0]    data;
    logic                 calm;
  } item_t;

  typedef struct packed {
    logic          chan;
    logic [DW-1:0] sample;
  } filtered_t;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [COEF_W-1:0]    cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DW-1:0]        s_axis_tdata  = '0;  // sample_in
  logic                 s_axis_tuser  = 1'b0;  // channel
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DW-1:0]        m_axis_tdata;  // sample_out
  logic                 m_axis_tuser;  // out_channel

  stereo_biquad_iir_filter_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  item_t     send_q [$];
  filtered_t filtered_q [$];

  coef_t  coef_m [COEF_COUNT];
  delay_t dly_first [CHANNELS_DEF];
  delay_t dly_second [CHANNELS_DEF];

  logic beat_taken = 1'b0;
  logic calm_now   = 1'b0;
  logic calm_mode  = 1'b0;
  int   quiet_cycles    = 0;
  int   cycle_cnt       = 0;
  int   mismatches      = 0;
  int   samples_in      = 0;
  int   writes_done     = 0;
  int   results_checked = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    end
  endtask

  // sample times coefficient, rounded half up to the Q.40 delay grid
  function automatic wide_t sample_term(wide_t x, wide_t c);
    return (x * c + (ONE << (IN_SH - 1))) >>> IN_SH;
  endfunction

  // Q.40 value times Q4.28 coefficient, rounded half up
  function automatic wide_t feedback_term(wide_t y, wide_t c);
    return (y * c + (ONE << (COEF_FRAC - 1))) >>> COEF_FRAC;
  endfunction

  function automatic wide_t clamp_delay(wide_t v);
    if (v > DLY_MAX) v = DLY_MAX;
    if (v < DLY_MIN) v = DLY_MIN;
    if (v >= -1 && v <= 1) v = 0;
    return v;
  endfunction

  function automatic filtered_t filter_sample(logic chan, logic signed [SW-1:0] x);
    wide_t     xs;
    wide_t     y;
    wide_t     n1;
    wide_t     n2;
    wide_t     s;
    filtered_t r;
    xs = x;
    y  = sample_term(xs, coef_m[REG_B0]) + dly_first[chan];
    n1 = clamp_delay(sample_term(xs, coef_m[REG_B1]) - feedback_term(y, coef_m[REG_A1])
                     + dly_second[chan]);
    n2 = clamp_delay(sample_term(xs, coef_m[REG_B2]) - feedback_term(y, coef_m[REG_A2]));
    dly_first[chan]  = n1[DELAY_W-1:0];
    dly_second[chan] = n2[DELAY_W-1:0];
    s = (y + (ONE << (OUT_SH - 1))) >>> OUT_SH;
    if (s > OUT_MAX) s = OUT_MAX;
    if (s < OUT_MIN) s = OUT_MIN;
    r.chan   = chan;
    r.sample = DW'(s[SW-1:0]);
    return r;
  endfunction

  function automatic int rand_span(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? S_MAX : S_MIN;
      1: return SW'(rand_span(16));
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic push_item(item_kind_e kind, logic chan, logic [SW-1:0] sample,
                           logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    item_t it;
    it.kind   = kind;
    it.chan   = chan;
    it.sample = sample;
    it.idx    = idx;
    it.data   = data;
    it.calm   = calm_mode;
    send_q.push_back(it);
  endtask

  task automatic load_coefs(coef_mode_e mode);
    coef_t c;
    for (int i = 0; i < COEF_COUNT; i++) begin
      case (mode)
        // b0..b2 come first in the register map
        MODE_STABLE: c = (i < 3) ? coef_t'(rand_span(B_SPAN)) : coef_t'(rand_span(A_SPAN));
        MODE_WILD:   c = coef_t'($urandom);
        MODE_MAX:    c = COEF_MAX;
        MODE_MIN:    c = COEF_MIN;
        default:     c = (COEF_IDX[i] == REG_B0) ? coef_t'($urandom) : coef_t'(0);
      endcase
      push_item(ITEM_WRITE, 1'b0, '0, COEF_IDX[i], c);
    end
  endtask

  // driver: beats change on the falling edge, writes and drains only once idle
  always @(negedge clk_i) begin : drive
    logic  vld;
    logic  we;
    item_t head;
    if (rst_ni) begin
      vld = s_axis_tvalid;
      we  = 1'b0;
      if (vld && beat_taken) begin
        void'(send_q.pop_front());
        vld = 1'b0;
      end
      if (!vld && send_q.size() != 0) begin
        head     = send_q[0];
        calm_now = head.calm;
        case (head.kind)
          ITEM_SAMPLE: begin
            if (head.calm || $urandom_range(0, 99) >= IDLE_PCT) begin
              vld = 1'b1;
              s_axis_tdata <= DW'(head.sample);
              s_axis_tuser <= head.chan;
            end
          end
          ITEM_WRITE: begin
            if (filtered_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
              we = 1'b1;
              cfg_idx_i  <= head.idx;
              cfg_data_i <= head.data;
              void'(send_q.pop_front());
            end
          end
          default: begin
            if (filtered_q.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
              void'(send_q.pop_front());
            end
          end
        endcase
      end
      s_axis_tvalid <= vld;
      cfg_we_i      <= we;
      m_axis_tready <= calm_now || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // monitor and model: everything sampled on the rising edge
  always @(posedge clk_i) begin : observe
    filtered_t            want;
    logic signed [SW-1:0] x;
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               filtered_q.size());
      $display("TB_ERROR");
      $finish;
    end else if (!rst_ni) begin
      foreach (coef_m[i]) coef_m[i] = COEF_RESET[i];
      foreach (dly_first[i]) begin
        dly_first[i]  = '0;
        dly_second[i] = '0;
      end
      beat_taken   = 1'b0;
      quiet_cycles = 0;
    end else begin
      if (cfg_we_i) begin
        writes_done++;
        if (cfg_idx_i < COEF_COUNT) coef_m[cfg_idx_i] = cfg_data_i;
      end
      beat_taken = s_axis_tvalid && s_axis_tready;
      if (beat_taken) begin
        x = s_axis_tdata[SW-1:0];
        filtered_q.push_back(filter_sample(s_axis_tuser, x));
        samples_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (filtered_q.size() == 0) begin
          report_mismatch($sformatf("result beat %h with no sample outstanding", m_axis_tdata));
        end else begin
          want = filtered_q.pop_front();
          results_checked++;
          if (m_axis_tuser !== want.chan) begin
            report_mismatch($sformatf("channel: got %b, expected %b", m_axis_tuser, want.chan));
          end
          if (m_axis_tdata !== want.sample) begin
            report_mismatch($sformatf("sample on channel %0d: got %h, expected %h",
                                      want.chan, m_axis_tdata, want.sample));
          end
        end
      end
      quiet_cycles = (filtered_q.size() == 0) ? quiet_cycles + 1 : 0;
    end
  end

  initial begin : stimulus
    coef_mode_e mode;
    // reset coefficients give unity gain
    push_item(ITEM_SAMPLE, 1'b0, S_MAX, '0, '0);
    push_item(ITEM_SAMPLE, 1'b1, S_MIN, '0, '0);
    push_item(ITEM_SAMPLE, 1'b0, SW'(1), '0, '0);
    push_item(ITEM_SAMPLE, 1'b1, '1, '0, '0);
    // unmapped indexes must not touch the coefficients
    push_item(ITEM_WRITE, 1'b0, '0, FIRST_UNMAPPED, $urandom);
    push_item(ITEM_WRITE, 1'b0, '0, FIRST_UNMAPPED + CFG_IDX_W'(1), $urandom);
    push_item(ITEM_WRITE, 1'b0, '0, '1, $urandom);
    push_item(ITEM_SAMPLE, 1'b0, SW'($urandom), '0, '0);
    // tiny delays: +1 and -1 LSB are flushed, +2 survives and is blown up by a1 = -8
    push_item(ITEM_WRITE, 1'b0, '0, REG_B0, '0);
    push_item(ITEM_WRITE, 1'b0, '0, REG_B1, TIE_COEF);
    push_item(ITEM_WRITE, 1'b0, '0, REG_A1, COEF_MIN);
    push_item(ITEM_SAMPLE, 1'b0, SW'(1), '0, '0);
    push_item(ITEM_SAMPLE, 1'b1, SW'(-2), '0, '0);
    push_item(ITEM_SAMPLE, 1'b1, SW'(3), '0, '0);
    repeat (6) begin
      push_item(ITEM_SAMPLE, 1'b0, '0, '0, '0);
      push_item(ITEM_SAMPLE, 1'b1, '0, '0, '0);
    end
    // output saturation
    push_item(ITEM_WRITE, 1'b0, '0, REG_B0, COEF_MAX);
    push_item(ITEM_WRITE, 1'b0, '0, REG_B1, '0);
    push_item(ITEM_WRITE, 1'b0, '0, REG_B2, '0);
    push_item(ITEM_WRITE, 1'b0, '0, REG_A1, '0);
    push_item(ITEM_WRITE, 1'b0, '0, REG_A2, '0);
    push_item(ITEM_SAMPLE, 1'b0, S_MAX, '0, '0);
    push_item(ITEM_SAMPLE, 1'b1, S_MIN, '0, '0);
    // delay overflow
    push_item(ITEM_WRITE, 1'b0, '0, REG_B1, COEF_MAX);
    push_item(ITEM_WRITE, 1'b0, '0, REG_B2, COEF_MAX);
    push_item(ITEM_WRITE, 1'b0, '0, REG_A1, COEF_MIN);
    push_item(ITEM_WRITE, 1'b0, '0, REG_A2, COEF_MIN);
    repeat (3) push_item(ITEM_SAMPLE, 1'b0, S_MAX, '0, '0);
    push_item(ITEM_SAMPLE, 1'b1, S_MIN, '0, '0);

    for (int p = 0; p < PHASES; p++) begin
      calm_mode = (p == CALM_PHASE);
      mode = coef_mode_e'(p % 5);
      push_item(ITEM_DRAIN, 1'b0, '0, '0, '0);
      load_coefs(mode);
      if ($urandom_range(0, 1)) begin
        push_item(ITEM_WRITE, 1'b0, '0,
                  FIRST_UNMAPPED + CFG_IDX_W'($urandom_range(0, 2)), $urandom);
      end
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 49) == 0) push_item(ITEM_DRAIN, 1'b0, '0, '0, '0);
        push_item(ITEM_SAMPLE, 1'($urandom), pick_sample(), '0, '0);
      end
    end
    calm_mode = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (send_q.size() != 0 || filtered_q.size() != 0) @(posedge clk_i);
    repeat (4 * LATENCY) @(posedge clk_i);

    $display("%0d sample beats in, %0d coefficient writes, %0d result beats checked",
             samples_in, writes_done, results_checked);
    $display("coefficient sets: reset, tiny-delay, saturating, overflow, %0d random phases",
             PHASES);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
